>>> sv/bitmap_first_fit_allocator_assert.svh
// Assertion macros for the bitmap first-fit allocator.
// Used by sv/bitmap_first_fit_allocator.sv; no other dependencies.
`ifndef BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`define BITMAP_FIRST_FIT_ALLOCATOR_ASSERT_SVH
`ifndef SYNTHESIS
`define BFFA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bffa assertion failed");
`define BFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bffa assertion failed");
`else
`define BFFA_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define BFFA_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

>>> sv/bffa_pkg.sv
// Shared types and constants for the bitmap first-fit allocator.
// No dependencies.
package bffa_pkg;

  localparam int MAX_WORDS_DEF     = 256;
  localparam int INITIAL_WORDS_DEF = 8;
  localparam int MIN_WORDS         = 8;
  localparam int GROWTH            = 2;

  localparam int CMD_W       = 2;
  localparam int START_W     = 8;
  localparam int LEN_W       = 9;
  localparam int OUT_W       = 9;
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [CMD_W-1:0] {
    CMD_FIND,
    CMD_MARK,
    CMD_RELEASE,
    CMD_HALVE
  } cmd_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_FIND,
    S_WRITE,
    S_RESP
  } state_t;

endpackage

>>> sv/bitmap_first_fit_allocator.sv
// Find: one bitmap word per cycle is scanned from accept to result.
// Mark/release write their words (none for zero length or a failing mark); halve frees
// the words above the new capacity. One item at a time: in_tready is high only while idle;
// a held result stalls it. Reset (rst_n low, synchronous) clears control state, then a
// clearing pass frees every bitmap word before the first item is taken.
// Depends on bffa_pkg and bitmap_first_fit_allocator_assert.svh.
`include "bitmap_first_fit_allocator_assert.svh"

module bitmap_first_fit_allocator #(
  parameter int MAX_WORDS     = bffa_pkg::MAX_WORDS_DEF,
  parameter int INITIAL_WORDS = bffa_pkg::INITIAL_WORDS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [bffa_pkg::IN_TDATA_W-1:0]    in_tdata,   // start_index[7:0], run_length[16:8]
  input  logic [bffa_pkg::CMD_W-1:0]         in_tuser,   // cmd[1:0]
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [bffa_pkg::OUT_TDATA_W-1:0]   out_tdata,  // found_index[8:0], capacity[17:9],
                                                         // used_count[26:18]
  output logic [0:0]                         out_tuser   // error[0]
);

  localparam int AW = $clog2(MAX_WORDS);
  localparam int CW = $clog2(MAX_WORDS + 1);
  localparam int XW = ((CW > bffa_pkg::LEN_W) ? CW : bffa_pkg::LEN_W) + 1;
  localparam int INIT_CAP = (INITIAL_WORDS < bffa_pkg::MIN_WORDS) ? bffa_pkg::MIN_WORDS :
                            ((INITIAL_WORDS > MAX_WORDS) ? MAX_WORDS : INITIAL_WORDS);
  localparam int PAD_W = bffa_pkg::OUT_TDATA_W - 3 * bffa_pkg::OUT_W;

  bffa_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    cap_r, cap_nxt;
  logic [CW-1:0]    used_r, used_nxt;
  logic [CW-1:0]    found_r, found_nxt;
  logic             err_r, err_nxt;
  logic [XW-1:0]    len_r, len_nxt;
  logic [XW-1:0]    scan_r, scan_nxt;
  logic             pend_r, pend_nxt;
  logic [XW-1:0]    run_r, run_nxt;
  logic [XW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [XW-1:0]    wr_end_r, wr_end_nxt;
  logic             wr_val_r, wr_val_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [bffa_pkg::OUT_TDATA_W-1:0] out_tdata_r, out_tdata_nxt;
  logic [0:0]       out_tuser_r, out_tuser_nxt;

  logic             mem_r [MAX_WORDS];
  logic             rd_data_r;
  logic             rd_en;
  logic             wr_en;

  bffa_pkg::cmd_t   in_cmd;
  logic [XW-1:0]    start_x, len_x, end_x, cap_x, used_x;
  logic [XW-1:0]    cap_grow, cap_mark, cap_half, stop_x, used_add, used_sat, used_sub;
  logic [XW-1:0]    run_inc;

  assign in_tready  = (state_r == bffa_pkg::S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_tdata_r;
  assign out_tuser  = out_tuser_r;

  assign in_cmd  = bffa_pkg::cmd_t'(in_tuser);
  assign start_x = XW'(in_tdata[bffa_pkg::START_W-1:0]);
  assign len_x   = XW'(in_tdata[bffa_pkg::START_W +: bffa_pkg::LEN_W]);
  assign end_x   = start_x + len_x;
  assign cap_x   = XW'(cap_r);
  assign used_x  = XW'(used_r);

  assign cap_grow = (cap_x * XW'(bffa_pkg::GROWTH) > XW'(MAX_WORDS)) ? XW'(MAX_WORDS) :
                    cap_x * XW'(bffa_pkg::GROWTH);
  assign cap_mark = (end_x > cap_x) ? cap_grow : cap_x;
  assign cap_half = ((cap_x >> 1) < XW'(bffa_pkg::MIN_WORDS)) ? XW'(bffa_pkg::MIN_WORDS) :
                    (cap_x >> 1);
  assign stop_x   = (end_x < cap_x) ? end_x : cap_x;
  assign used_add = used_x + len_x;
  assign used_sat = (used_add > XW'(MAX_WORDS)) ? XW'(MAX_WORDS) : used_add;
  assign used_sub = (used_x > len_x) ? (used_x - len_x) : '0;
  assign run_inc  = run_r + XW'(1);

  assign rd_en = (state_r == bffa_pkg::S_FIND) && (scan_r < cap_x);
  assign wr_en = ((state_r == bffa_pkg::S_WRITE) || (state_r == bffa_pkg::S_CLEAR)) &&
                 (wr_ptr_r < wr_end_r);

  always_comb begin
    state_nxt      = state_r;
    cap_nxt        = cap_r;
    used_nxt       = used_r;
    found_nxt      = found_r;
    err_nxt        = err_r;
    len_nxt        = len_r;
    scan_nxt       = scan_r;
    pend_nxt       = pend_r;
    run_nxt        = run_r;
    wr_ptr_nxt     = wr_ptr_r;
    wr_end_nxt     = wr_end_r;
    wr_val_nxt     = wr_val_r;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_tdata_nxt  = out_tdata_r;
    out_tuser_nxt  = out_tuser_r;

    case (state_r)
      bffa_pkg::S_CLEAR: begin
        if (wr_en) begin
          wr_ptr_nxt = wr_ptr_r + XW'(1);
        end else begin
          state_nxt = bffa_pkg::S_IDLE;
        end
      end
      bffa_pkg::S_IDLE: begin
        if (in_tvalid) begin
          found_nxt = '0;
          err_nxt   = 1'b0;
          case (in_cmd)
            bffa_pkg::CMD_FIND: begin
              len_nxt   = len_x;
              scan_nxt  = '0;
              pend_nxt  = 1'b0;
              run_nxt   = '0;
              state_nxt = bffa_pkg::S_FIND;
            end
            bffa_pkg::CMD_MARK: begin
              if (len_x == '0) begin
                state_nxt = bffa_pkg::S_RESP;
              end else if (end_x > cap_mark) begin
                err_nxt   = 1'b1;
                state_nxt = bffa_pkg::S_RESP;
              end else begin
                cap_nxt    = CW'(cap_mark);
                used_nxt   = CW'(used_sat);
                wr_ptr_nxt = start_x;
                wr_end_nxt = end_x;
                wr_val_nxt = 1'b1;
                state_nxt  = bffa_pkg::S_WRITE;
              end
            end
            bffa_pkg::CMD_RELEASE: begin
              if (len_x == '0) begin
                state_nxt = bffa_pkg::S_RESP;
              end else begin
                used_nxt   = CW'(used_sub);
                wr_ptr_nxt = start_x;
                wr_end_nxt = stop_x;
                wr_val_nxt = 1'b0;
                state_nxt  = bffa_pkg::S_WRITE;
              end
            end
            bffa_pkg::CMD_HALVE: begin
              cap_nxt    = CW'(cap_half);
              wr_ptr_nxt = cap_half;
              wr_end_nxt = cap_x;
              wr_val_nxt = 1'b0;
              state_nxt  = bffa_pkg::S_WRITE;
            end
            default: begin
              state_nxt = bffa_pkg::S_RESP;
            end
          endcase
        end
      end
      bffa_pkg::S_FIND: begin
        scan_nxt = rd_en ? (scan_r + XW'(1)) : scan_r;
        pend_nxt = rd_en;
        if (pend_r) begin
          if (!rd_data_r) begin
            run_nxt = run_inc;
            if (run_inc == len_r) begin
              found_nxt = CW'(scan_r - len_r);
              state_nxt = bffa_pkg::S_RESP;
            end
          end else begin
            run_nxt = '0;
          end
        end else if (!rd_en) begin
          found_nxt = CW'(cap_x - run_r);
          state_nxt = bffa_pkg::S_RESP;
        end
      end
      bffa_pkg::S_WRITE: begin
        if (wr_en) begin
          wr_ptr_nxt = wr_ptr_r + XW'(1);
        end else begin
          state_nxt = bffa_pkg::S_RESP;
        end
      end
      bffa_pkg::S_RESP: begin
        if (!out_tvalid_r || out_tready) begin
          out_tdata_nxt  = {PAD_W'(0), bffa_pkg::OUT_W'(used_r), bffa_pkg::OUT_W'(cap_r),
                            bffa_pkg::OUT_W'(found_r)};
          out_tuser_nxt  = err_r;
          out_tvalid_nxt = 1'b1;
          state_nxt      = bffa_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bffa_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bffa_pkg::S_CLEAR;
      cap_r        <= CW'(INIT_CAP);
      used_r       <= '0;
      pend_r       <= 1'b0;
      wr_ptr_r     <= '0;
      wr_end_r     <= XW'(MAX_WORDS);
      wr_val_r     <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cap_r        <= cap_nxt;
      used_r       <= used_nxt;
      pend_r       <= pend_nxt;
      wr_ptr_r     <= wr_ptr_nxt;
      wr_end_r     <= wr_end_nxt;
      wr_val_r     <= wr_val_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    found_r     <= found_nxt;
    err_r       <= err_nxt;
    len_r       <= len_nxt;
    scan_r      <= scan_nxt;
    run_r       <= run_nxt;
    out_tdata_r <= out_tdata_nxt;
    out_tuser_r <= out_tuser_nxt;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r[AW-1:0]] <= wr_val_r;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[scan_r[AW-1:0]];
    end
  end

  `BFFA_ASSERT_NOW(a_cap_min, clk, rst_n, 1'b1, cap_r >= CW'(bffa_pkg::MIN_WORDS))
  `BFFA_ASSERT_NOW(a_cap_max, clk, rst_n, 1'b1, cap_r <= CW'(MAX_WORDS))
  `BFFA_ASSERT_NOW(a_used_range, clk, rst_n, 1'b1, used_r <= CW'(MAX_WORDS))
  `BFFA_ASSERT_NEXT(a_accept_busy, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `BFFA_ASSERT_NOW(a_wr_addr, clk, rst_n, wr_en, wr_ptr_r < XW'(MAX_WORDS))
  `BFFA_ASSERT_NOW(a_scan_bound, clk, rst_n, state_r == bffa_pkg::S_FIND, scan_r <= cap_x)

endmodule

>>> bench/allocator_checker.sv
// Checker for the bitmap first-fit allocator: watches both streams, predicts each result
// from its own copy of the bitmap, capacity and used count, and counts mismatches.
// Depends on bffa_pkg.
module allocator_checker #(
  parameter int MAX_WORDS     = bffa_pkg::MAX_WORDS_DEF,
  parameter int INITIAL_WORDS = bffa_pkg::INITIAL_WORDS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [bffa_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [bffa_pkg::CMD_W-1:0]       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [bffa_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [0:0]                       out_tuser,
  output int                               mismatches,
  output int                               awaiting
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [bffa_pkg::OUT_W-1:0] found_index;
    logic [bffa_pkg::OUT_W-1:0] capacity;
    logic [bffa_pkg::OUT_W-1:0] used_count;
    logic                       error;
  } alloc_answer_t;

  logic          word_used [MAX_WORDS];
  int unsigned   cap_words;
  int unsigned   used_words;
  alloc_answer_t answers_due [$];

  initial begin
    mismatches = 0;
    awaiting = 0;
  end

  function automatic int unsigned clamp_words(input int unsigned words);
    if (words < bffa_pkg::MIN_WORDS) return bffa_pkg::MIN_WORDS;
    if (words > MAX_WORDS) return MAX_WORDS;
    return words;
  endfunction

  function automatic alloc_answer_t apply_alloc_cmd(input bffa_pkg::cmd_t cmd,
                                                    input int unsigned start,
                                                    input int unsigned len);
    alloc_answer_t ans;
    int unsigned   run;
    int            hit;
    int unsigned   stop;
    int unsigned   grown;
    ans = '0;
    case (cmd)
      bffa_pkg::CMD_FIND: begin
        run = 0;
        hit = -1;
        for (int unsigned i = 0; i < cap_words; i++) begin
          if (!word_used[i]) begin
            run++;
            if (run == len && hit < 0) hit = i + 1 - len;
          end else begin
            run = 0;
          end
        end
        ans.found_index = (hit >= 0) ? bffa_pkg::OUT_W'(hit)
                                     : bffa_pkg::OUT_W'(cap_words - run);
      end
      bffa_pkg::CMD_MARK: begin
        if (len != 0) begin
          grown = cap_words;
          if (start + len > grown) grown = clamp_words(grown * bffa_pkg::GROWTH);
          if (start + len > grown) begin
            ans.error = 1'b1;
          end else begin
            cap_words = grown;
            for (int unsigned i = start; i < start + len; i++) word_used[i] = 1'b1;
            used_words += len;
            if (used_words > MAX_WORDS) used_words = MAX_WORDS;
          end
        end
      end
      bffa_pkg::CMD_RELEASE: begin
        if (len != 0) begin
          stop = (start + len < cap_words) ? start + len : cap_words;
          for (int unsigned i = start; i < stop; i++) word_used[i] = 1'b0;
          used_words = (used_words > len) ? used_words - len : 0;
        end
      end
      default: begin
        grown = clamp_words(cap_words / bffa_pkg::GROWTH);
        for (int unsigned i = grown; i < cap_words; i++) word_used[i] = 1'b0;
        cap_words = grown;
      end
    endcase
    ans.capacity   = bffa_pkg::OUT_W'(cap_words);
    ans.used_count = bffa_pkg::OUT_W'(used_words);
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    $display("%0t ns: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    mismatches++;
  endtask

  always @(posedge clk) begin
    alloc_answer_t want;
    if (!rst_n) begin
      foreach (word_used[i]) word_used[i] = 1'b0;
      cap_words  = clamp_words(INITIAL_WORDS);
      used_words = 0;
      answers_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (answers_due.size() == 0) begin
          report_mismatch("result with nothing outstanding", int'(out_tdata[8:0]), -1);
        end else begin
          want = answers_due.pop_front();
          if (out_tdata[8:0] !== want.found_index)
            report_mismatch("found_index", int'(out_tdata[8:0]), int'(want.found_index));
          if (out_tdata[17:9] !== want.capacity)
            report_mismatch("capacity", int'(out_tdata[17:9]), int'(want.capacity));
          if (out_tdata[26:18] !== want.used_count)
            report_mismatch("used_count", int'(out_tdata[26:18]), int'(want.used_count));
          if (out_tuser[0] !== want.error)
            report_mismatch("error", int'(out_tuser[0]), int'(want.error));
        end
      end
      if (in_tvalid && in_tready)
        answers_due.push_back(apply_alloc_cmd(bffa_pkg::cmd_t'(in_tuser),
                                              32'(in_tdata[7:0]), 32'(in_tdata[16:8])));
    end
    awaiting = answers_due.size();
  end

endmodule

>>> bench/tb_bitmap_first_fit_allocator.sv
// Top of the allocator bench: clock, reset, directed and random command streams with
// random idling on both sides, and the verdict. Depends on bffa_pkg, allocator_checker
// and bitmap_first_fit_allocator.
module tb_bitmap_first_fit_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 880;
  localparam int CALM_ITEMS   = 120;
  localparam int LONG_HOLD    = 400;

  logic                             clk        = 1'b0;
  logic                             rst_n      = 1'b0;
  logic                             in_tvalid  = 1'b0;
  logic                             in_tready;
  logic [bffa_pkg::IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [bffa_pkg::CMD_W-1:0]       in_tuser   = '0;
  logic                             out_tvalid;
  logic                             out_tready = 1'b0;
  logic [bffa_pkg::OUT_TDATA_W-1:0] out_tdata;
  logic [0:0]                       out_tuser;
  logic                             calm       = 1'b0;
  logic                             hold_req   = 1'b0;
  int unsigned                      seen_cap   = bffa_pkg::INITIAL_WORDS_DEF;
  int                               mismatches;
  int                               awaiting;

  bitmap_first_fit_allocator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  allocator_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (out_tvalid && out_tready) seen_cap <= {23'd0, out_tdata[17:9]};
  end

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 40;
    endcase
  endfunction

  task automatic send_item(input bffa_pkg::cmd_t cmd, input int unsigned start,
                           input int unsigned len);
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {7'd0, len[8:0], start[7:0]};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    in_tvalid <= 1'b0;
    in_tdata  <= bffa_pkg::IN_TDATA_W'($urandom);
    in_tuser  <= bffa_pkg::CMD_W'($urandom);
    repeat (cycles) @(negedge clk);
  endtask

  task automatic send_random();
    int unsigned    r;
    int unsigned    cap;
    int unsigned    start;
    int unsigned    len;
    bffa_pkg::cmd_t cmd;
    cap = seen_cap;
    r = $urandom_range(0, 99);
    if (r < 5) begin
      cmd   = bffa_pkg::cmd_t'($urandom_range(0, 3));
      start = $urandom_range(0, 255);
      len   = $urandom_range(0, 256);
    end else if (r < 38) begin
      cmd   = bffa_pkg::CMD_FIND;
      start = $urandom_range(0, 255);
      len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, (cap < 254) ? cap + 2 : 256)
                                          : $urandom_range(1, 16);
    end else if (r < 72) begin
      cmd   = bffa_pkg::CMD_MARK;
      start = $urandom_range(0, ((2 * cap > 256) ? 256 : 2 * cap) - 1);
      len   = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 64) : $urandom_range(1, 12);
    end else if (r < 92) begin
      cmd   = bffa_pkg::CMD_RELEASE;
      start = $urandom_range(0, cap - 1);
      len   = $urandom_range(1, 32);
    end else begin
      cmd   = bffa_pkg::CMD_HALVE;
      start = $urandom_range(0, 255);
      len   = $urandom_range(0, 256);
    end
    send_item(cmd, start, len);
  endtask

  initial begin
    int stall_left;
    int stall_pct;
    bit hold_done;
    stall_left = 0;
    stall_pct  = 0;
    hold_done  = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 63) == 0) stall_pct = pick_idle_pct();
      if (hold_req && !hold_done) begin
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_done = 1'b1;
        out_tready <= 1'b1;
      end else if (calm) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 9);
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    int gap_pct;
    gap_pct = 0;
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    send_item(bffa_pkg::CMD_FIND, 0, 1);
    send_item(bffa_pkg::CMD_FIND, 0, 0);
    send_item(bffa_pkg::CMD_FIND, 0, 9);
    send_item(bffa_pkg::CMD_MARK, 0, 0);
    send_item(bffa_pkg::CMD_MARK, 0, 3);
    send_item(bffa_pkg::CMD_FIND, 0, 2);
    send_item(bffa_pkg::CMD_MARK, 6, 4);
    send_item(bffa_pkg::CMD_MARK, 200, 56);
    send_item(bffa_pkg::CMD_FIND, 0, 16);
    send_item(bffa_pkg::CMD_MARK, 2, 3);
    send_item(bffa_pkg::CMD_RELEASE, 0, 0);
    send_item(bffa_pkg::CMD_RELEASE, 250, 6);
    send_item(bffa_pkg::CMD_HALVE, 0, 0);
    send_item(bffa_pkg::CMD_HALVE, 255, 256);
    send_item(bffa_pkg::CMD_RELEASE, 0, 256);
    send_item(bffa_pkg::CMD_MARK, 8, 8);
    send_item(bffa_pkg::CMD_MARK, 16, 16);
    send_item(bffa_pkg::CMD_MARK, 32, 32);
    send_item(bffa_pkg::CMD_MARK, 64, 64);
    send_item(bffa_pkg::CMD_MARK, 128, 128);
    send_item(bffa_pkg::CMD_MARK, 0, 256);
    send_item(bffa_pkg::CMD_MARK, 255, 2);
    send_item(bffa_pkg::CMD_FIND, 0, 256);
    send_item(bffa_pkg::CMD_RELEASE, 0, 256);
    send_item(bffa_pkg::CMD_FIND, 0, 256);
    send_item(bffa_pkg::CMD_HALVE, 0, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 50 == 0) gap_pct = pick_idle_pct();
      if (n == 250) hold_req = 1'b1;
      if (n == 500 || n == 700) begin
        idle_sender(1);
        while (awaiting != 0) @(negedge clk);
      end
      if (n == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
      if (!calm && $urandom_range(0, 99) < gap_pct) idle_sender($urandom_range(1, 10));
      send_random();
    end
    idle_sender(0);

    while (awaiting != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #(15_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule

>>> sim.f
+incdir+sv
sv/bffa_pkg.sv
sv/bitmap_first_fit_allocator.sv
bench/allocator_checker.sv
bench/tb_bitmap_first_fit_allocator.sv
